>>> hw/rtl/q2e_pkg.sv
package q2e_pkg;

   // Default build parameters
   localparam int CORDIC_STEPS_DEF       = 16;
   localparam int QUAT_FRACTION_BITS_DEF = 14;

   // Angle format: 1/65536 degree, signed
   localparam int ANG_W    = 26;
   localparam int ATAN_LEN = 24;

   localparam logic signed [ANG_W-1:0] ANG_90  = 26'sd5898240;
   localparam logic signed [ANG_W-1:0] ANG_180 = 26'sd11796480;

   // atan(2^-i) in 1/65536 degree, rounded to nearest
   localparam logic signed [ANG_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
      26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
      26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
      26'sd917,     26'sd458,     26'sd229,    26'sd115,
      26'sd57,      26'sd29,      26'sd14,     26'sd7,
      26'sd4,       26'sd2,       26'sd1,      26'sd0
   };

   // Cosine square root: radicand 2^60 - s^2, one result bit per cell
   localparam int RAD_W      = 61;
   localparam int ROOT_STEPS = 31;
   localparam int SIN_W      = 31;

   // Output limits in 1/128 degree
   localparam int ROLL_LIM  = 23040;
   localparam int PITCH_LIM = 11520;
   localparam int YAW_LIM   = 46080;

   // One result beat
   typedef struct packed {
      logic               clamped;
      logic        [15:0] yaw;
      logic signed [14:0] pitch;
      logic signed [15:0] roll;
   } rsp_beat_type;

endpackage

>>> hw/rtl/q2e_root_cell.sv
module q2e_root_cell #(
   parameter int BIT_POS = 60
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [q2e_pkg::RAD_W-1:0]     rem_i,
   input  logic [q2e_pkg::RAD_W-1:0]     root_i,
   output logic [q2e_pkg::RAD_W-1:0]     rem_o,
   output logic [q2e_pkg::RAD_W-1:0]     root_o
);

   localparam int RW = q2e_pkg::RAD_W;
   localparam logic [RW:0] BIT_VAL = (RW+1)'(1) << BIT_POS;

   logic [RW:0]   trial;
   logic [RW-1:0] rem_in, rem_ff;
   logic [RW-1:0] root_in, root_ff;

   // Try to subtract root + bit from the remainder
   always_comb begin
      trial = {1'b0, root_i} + BIT_VAL;
      if ({1'b0, rem_i} >= trial) begin
         rem_in  = RW'({1'b0, rem_i} - trial);
         root_in = RW'({2'b00, root_i[RW-1:1]} + BIT_VAL);
      end else begin
         rem_in  = rem_i;
         root_in = {1'b0, root_i[RW-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

>>> hw/rtl/q2e_cordic_cell.sv
module q2e_cordic_cell #(
   parameter int STEP = 0,
   parameter int DW   = 36
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [DW-1:0]                 x_i,
   input  logic signed [DW-1:0]                 y_i,
   input  logic signed [q2e_pkg::ANG_W-1:0]     z_i,
   output logic signed [DW-1:0]                 x_o,
   output logic signed [DW-1:0]                 y_o,
   output logic signed [q2e_pkg::ANG_W-1:0]     z_o
);

   localparam int AW = q2e_pkg::ANG_W;
   localparam logic signed [AW-1:0] ANG =
      (STEP < q2e_pkg::ATAN_LEN) ? q2e_pkg::ATAN_TABLE[STEP] : '0;

   logic signed [DW-1:0] x_in, x_ff, y_in, y_ff;
   logic signed [AW-1:0] z_in, z_ff;

   // Rotate toward y = 0
   always_comb begin
      if (y_i > 0) begin
         x_in = x_i + (y_i >>> STEP);
         y_in = y_i - (x_i >>> STEP);
         z_in = z_i + ANG;
      end else begin
         x_in = x_i - (y_i >>> STEP);
         y_in = y_i + (x_i >>> STEP);
         z_in = z_i - ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule

>>> hw/rtl/quaternion_to_euler_angles_unit.sv
// Attitude quaternion to ZYX Euler angles.
// Input channel req_: one beat carries w, x, y, z as signed fixed point
// with QUAT_FRACTION_BITS fraction bits. Result channel rsp_: one beat per
// input beat with roll, pitch and yaw (yaw offset by +180 degrees) in
// 1/128 degree, and a tuser flag set when the asin argument reached one
// and pitch was clamped to +-90 degrees.
// Stages: a beat passes six product and setup stages (the first loads at
// the accepting edge), 31 cells of the bit-per-cell cosine square root,
// one pre-rotation stage, CORDIC_STEPS CORDIC cells per angle, one
// rounding stage and the output register.
// Throughput: one beat per cycle while the output buffer is not full; every stage is a register in a chain.
// Reset clears all valid bits and the output buffer and holds req_tready
// low; data registers are not cleared. When the receiver stalls, a
// two-entry output buffer takes the beat leaving the chain; once both
// entries are full the whole chain freezes and req_tready drops until
// rsp_tready returns.
module quaternion_to_euler_angles_unit #(
   parameter int CORDIC_STEPS       = q2e_pkg::CORDIC_STEPS_DEF,
   parameter int QUAT_FRACTION_BITS = q2e_pkg::QUAT_FRACTION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // roll_deg, pitch_deg, yaw_deg, zero pad
   output logic        rsp_tuser    // pitch_clamped
);

   localparam int F      = QUAT_FRACTION_BITS;
   localparam int SUM_W  = ((2*F > 32) ? 2*F : 32) + 2;
   localparam int CW     = SUM_W + 2;
   localparam int AW     = q2e_pkg::ANG_W;
   localparam int SW     = q2e_pkg::SIN_W;
   localparam int RW     = q2e_pkg::RAD_W;
   localparam int NR     = q2e_pkg::ROOT_STEPS;
   localparam int LSH    = (2*F < 30) ? 30 - 2*F : 0;
   localparam int RSH    = (2*F >= 30) ? 2*F - 30 : 0;
   localparam int SHW    = SUM_W + LSH;
   localparam int DLY    = NR + 2;
   localparam int SIDE_W = 4*SUM_W + 2 + SW;
   localparam int NV     = NR + 8 + CORDIC_STEPS;
   localparam logic signed [SUM_W-1:0] ONE2 = SUM_W'(1) << (2*F);
   localparam logic [RW-1:0] RAD_ONE = RW'(1) << (RW - 1);

   logic en;
   logic [NV-1:0] valid_ff;

   logic signed [15:0] w_ff, x_ff, y_ff, z_ff;
   logic signed [31:0] p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_wz_ff;
   logic signed [31:0] p_xy_ff, p_zz_ff, p_wy_ff, p_zx_ff;
   logic signed [SUM_W-1:0] sr_ff, cr_ff, sy_ff, cy_ff, sp_ff;
   logic signed [SUM_W-1:0] sp_mag;
   logic signed [SHW-1:0]   sp_wide, s_shift;
   logic signed [SW-1:0]    s30_in;
   logic [SW-1:0]           mag_in, mag_ff;
   logic                    clamp_in;
   logic [RW-1:0]           sq_ff, rad_ff;
   logic [SIDE_W-1:0]       side_ff [DLY+1];

   logic [RW-1:0] rem_c  [NR+1];
   logic [RW-1:0] root_c [NR+1];

   logic signed [CW-1:0] x0 [3];
   logic signed [CW-1:0] y0 [3];
   logic signed [CW-1:0] px_in [3];
   logic signed [CW-1:0] py_in [3];
   logic signed [AW-1:0] pz_in [3];
   logic [2:0]           zero_in;
   logic signed [CW-1:0] xc [3][CORDIC_STEPS+1];
   logic signed [CW-1:0] yc [3][CORDIC_STEPS+1];
   logic signed [AW-1:0] zc [3][CORDIC_STEPS+1];
   logic [4:0]           side2_ff [CORDIC_STEPS+1];

   logic                 clamp_d, sign_d;
   logic signed [SW-1:0] s30_d;

   logic signed [AW:0]   roll_r, yaw_r, pitch_r;
   logic signed [AW:0]   roll_s, yaw_s, pitch_s;
   q2e_pkg::rsp_beat_type beat_in, beat_ff, out_ff, skid_ff;
   logic out_vld_ff, skid_vld_ff, take, new_beat;

   // Advance the whole chain unless the output buffer is full
   assign en         = !skid_vld_ff;
   assign req_tready = en && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NV-2:0], req_tvalid};
      end
   end

   // Capture, multiply, sum
   always_ff @(posedge clock) begin
      if (en) begin
         w_ff    <= req_tdata[15:0];
         x_ff    <= req_tdata[31:16];
         y_ff    <= req_tdata[47:32];
         z_ff    <= req_tdata[63:48];
         p_wx_ff <= w_ff * x_ff;
         p_yz_ff <= y_ff * z_ff;
         p_xx_ff <= x_ff * x_ff;
         p_yy_ff <= y_ff * y_ff;
         p_wz_ff <= w_ff * z_ff;
         p_xy_ff <= x_ff * y_ff;
         p_zz_ff <= z_ff * z_ff;
         p_wy_ff <= w_ff * y_ff;
         p_zx_ff <= z_ff * x_ff;
         sr_ff   <= (SUM_W'(p_wx_ff) + SUM_W'(p_yz_ff)) <<< 1;
         cr_ff   <= ONE2 - ((SUM_W'(p_xx_ff) + SUM_W'(p_yy_ff)) <<< 1);
         sy_ff   <= (SUM_W'(p_wz_ff) + SUM_W'(p_xy_ff)) <<< 1;
         cy_ff   <= ONE2 - ((SUM_W'(p_yy_ff) + SUM_W'(p_zz_ff)) <<< 1);
         sp_ff   <= (SUM_W'(p_wy_ff) - SUM_W'(p_zx_ff)) <<< 1;
      end
   end

   // Pitch sine: range check and rescale to 30 fraction bits
   always_comb begin
      sp_mag   = sp_ff[SUM_W-1] ? -sp_ff : sp_ff;
      clamp_in = $unsigned(sp_mag) >= $unsigned(ONE2);
      sp_wide  = SHW'(sp_ff);
      if (2*F >= 30) begin
         s_shift = sp_wide >>> RSH;
      end else begin
         s_shift = sp_wide <<< LSH;
      end
      s30_in = s_shift[SW-1:0];
      mag_in = s30_in[SW-1] ? SW'(-s30_in) : SW'(s30_in);
   end

   // Cosine radicand 2^60 - s^2, carry the rest alongside
   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff     <= mag_in;
         side_ff[0] <= {cr_ff, sr_ff, cy_ff, sy_ff, clamp_in, sp_ff[SUM_W-1], s30_in};
         sq_ff      <= RW'(mag_ff) * RW'(mag_ff);
         rad_ff     <= RAD_ONE - sq_ff;
         for (int k = 1; k <= DLY; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Square root, one result bit per cell
   assign rem_c[0]  = rad_ff;
   assign root_c[0] = '0;

   for (genvar k = 0; k < NR; k++) begin : g_root
      q2e_root_cell #(
         .BIT_POS (RW - 1 - 2*k)
      ) u_cell (
         .clock  (clock),
         .en     (en),
         .rem_i  (rem_c[k]),
         .root_i (root_c[k]),
         .rem_o  (rem_c[k+1]),
         .root_o (root_c[k+1])
      );
   end

   // Pre-rotate each vector into the right half plane
   always_comb begin
      s30_d   = side_ff[DLY][SW-1:0];
      sign_d  = side_ff[DLY][SW];
      clamp_d = side_ff[DLY][SW+1];
      x0[0] = CW'($signed(side_ff[DLY][SW+2+3*SUM_W +: SUM_W]));
      y0[0] = CW'($signed(side_ff[DLY][SW+2+2*SUM_W +: SUM_W]));
      x0[1] = CW'($signed(side_ff[DLY][SW+2+SUM_W +: SUM_W]));
      y0[1] = CW'($signed(side_ff[DLY][SW+2 +: SUM_W]));
      x0[2] = CW'($signed({1'b0, root_c[NR]}));
      y0[2] = CW'(s30_d);
      for (int c = 0; c < 3; c++) begin
         zero_in[c] = (x0[c] == '0) && (y0[c] == '0);
         if (x0[c] < 0) begin
            if (y0[c] >= 0) begin
               px_in[c] = y0[c];
               py_in[c] = -x0[c];
               pz_in[c] = q2e_pkg::ANG_90;
            end else begin
               px_in[c] = -y0[c];
               py_in[c] = x0[c];
               pz_in[c] = -q2e_pkg::ANG_90;
            end
         end else begin
            px_in[c] = x0[c];
            py_in[c] = y0[c];
            pz_in[c] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff[0] <= {zero_in, clamp_d, sign_d};
         for (int k = 1; k <= CORDIC_STEPS; k++) begin
            side2_ff[k] <= side2_ff[k-1];
         end
      end
   end

   // CORDIC rows: roll, yaw, pitch
   for (genvar c = 0; c < 3; c++) begin : g_chan
      // Load the pre-rotated vector into the first cell
      always_ff @(posedge clock) begin
         if (en) begin
            xc[c][0] <= px_in[c];
            yc[c][0] <= py_in[c];
            zc[c][0] <= pz_in[c];
         end
      end

      for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
         q2e_cordic_cell #(
            .STEP (k),
            .DW   (CW)
         ) u_cell (
            .clock (clock),
            .en    (en),
            .x_i   (xc[c][k]),
            .y_i   (yc[c][k]),
            .z_i   (zc[c][k]),
            .x_o   (xc[c][k+1]),
            .y_o   (yc[c][k+1]),
            .z_o   (zc[c][k+1])
         );
      end
   end

   // Round to 1/128 degree and saturate
   always_comb begin
      roll_r  = side2_ff[CORDIC_STEPS][2] ? '0 : (AW+1)'(zc[0][CORDIC_STEPS]);
      yaw_r   = side2_ff[CORDIC_STEPS][3] ? '0 : (AW+1)'(zc[1][CORDIC_STEPS]);
      pitch_r = side2_ff[CORDIC_STEPS][4] ? '0 : (AW+1)'(zc[2][CORDIC_STEPS]);
      yaw_r   = yaw_r + (AW+1)'(q2e_pkg::ANG_180);
      roll_s  = (roll_r + 27'sd256) >>> 9;
      yaw_s   = (yaw_r + 27'sd256) >>> 9;
      pitch_s = (pitch_r + 27'sd256) >>> 9;

      if (roll_s > q2e_pkg::ROLL_LIM) begin
         roll_s = (AW+1)'(q2e_pkg::ROLL_LIM);
      end else if (roll_s < -q2e_pkg::ROLL_LIM) begin
         roll_s = -(AW+1)'(q2e_pkg::ROLL_LIM);
      end
      if (yaw_s > q2e_pkg::YAW_LIM) begin
         yaw_s = (AW+1)'(q2e_pkg::YAW_LIM);
      end else if (yaw_s < 0) begin
         yaw_s = '0;
      end
      if (side2_ff[CORDIC_STEPS][1]) begin
         pitch_s = side2_ff[CORDIC_STEPS][0] ? -(AW+1)'(q2e_pkg::PITCH_LIM)
                                             : (AW+1)'(q2e_pkg::PITCH_LIM);
      end else if (pitch_s > q2e_pkg::PITCH_LIM) begin
         pitch_s = (AW+1)'(q2e_pkg::PITCH_LIM);
      end else if (pitch_s < -q2e_pkg::PITCH_LIM) begin
         pitch_s = -(AW+1)'(q2e_pkg::PITCH_LIM);
      end

      beat_in.clamped = side2_ff[CORDIC_STEPS][1];
      beat_in.roll    = roll_s[15:0];
      beat_in.pitch   = pitch_s[14:0];
      beat_in.yaw     = yaw_s[15:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         beat_ff <= beat_in;
      end
   end

   // Two-entry output buffer
   assign take     = out_vld_ff && rsp_tready;
   assign new_beat = en && valid_ff[NV-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (take) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (new_beat) begin
         if (out_vld_ff && !take) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end else if (take) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (new_beat) begin
         if (out_vld_ff && !take) begin
            skid_ff <= beat_ff;
         end else begin
            out_ff <= beat_ff;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_ff.yaw, out_ff.pitch, out_ff.roll};
   assign rsp_tuser  = out_ff.clamped;

endmodule

>>> hw/rtl/q2e_checker.sv
module q2e_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   // Reset empties the output buffer
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output not empty after reset");

   // Input stays closed while reset is high
   a_reset_closed: assert property (@(posedge clock)
      reset |-> !req_tready)
      else $error("req_tready high during reset");

   // Stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // Input closes only after a stalled result
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("req_tready dropped without a stall");

   // Clamped pitch sits at plus or minus 90 degrees
   a_clamp_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         $signed(rsp_tdata[30:16]) == 15'sd11520 ||
         $signed(rsp_tdata[30:16]) == -15'sd11520)
      else $error("clamped pitch not at limit");

endmodule

bind quaternion_to_euler_angles_unit q2e_checker u_q2e_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
